/* rtl/ccst_pkg.sv */
// Shared types and constants for the camera command socket tracker.
// Payload structs, op and result codes, socket phases and FIFO control.
// No dependencies.
package ccst_pkg;

  localparam int unsigned CCST_CMD_DEPTH = 16;
  localparam int unsigned CCST_INQ_DEPTH = 16;
  localparam int unsigned CCST_TAG_BITS  = 8;

  // Result queue between the execute step and the output channel
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = 2;
  localparam int unsigned RQ_CW    = 3;

  typedef enum logic [2:0] {
    OP_SUBMIT_CMD = 3'd0,
    OP_SUBMIT_INQ = 3'd1,
    OP_ACK        = 3'd2,
    OP_COMPLETION = 3'd3,
    OP_REPLY      = 3'd4,
    OP_ERROR      = 3'd5,
    OP_TIMEOUT    = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    KIND_SEND_CMD = 3'd0,
    KIND_SEND_INQ = 3'd1,
    KIND_CMD_DONE = 3'd2,
    KIND_INQ_DONE = 3'd3,
    KIND_REJECTED = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_AWAIT = 2'd1,
    PH_EXEC  = 2'd2
  } phase_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  localparam logic [1:0] SOCK_NONE = 2'd0;
  localparam logic [1:0] SOCK_ONE  = 2'd1;
  localparam logic [1:0] SOCK_TWO  = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tag;
    logic [1:0] socket;
    logic [7:0] error_code;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] result_tag;
    logic [1:0] result_socket;
    logic       success;
    logic [7:0] result_error;
    logic       last;
  } out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

/* rtl/ccst_tag_fifo.sv */
// Tag FIFO held in a synchronous memory with a registered head read.
// Depends on ccst_pkg for the control and status structs.
module ccst_tag_fifo
  import ccst_pkg::*;
#(
  parameter int unsigned DEPTH = CCST_CMD_DEPTH,
  parameter int unsigned WIDTH = CCST_TAG_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fifo_ctl_t        ctl_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] head_o,
  output fifo_stat_t       stat_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    head_q, head_d, tail;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW:0]      sum;
  logic [WIDTH-1:0] rdata_q;

  always_comb begin
    sum = (CW + 1)'(head_q) + (CW + 1)'(cnt_q);
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    tail = sum[AW-1:0];
  end

  always_comb begin
    head_d = head_q;
    if (ctl_i.pop) begin
      head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
    end
    unique case ({ctl_i.push, ctl_i.pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail] <= wdata_i;
    end
    rdata_q <= mem[head_q];
  end

  assign head_o       = rdata_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(DEPTH));

endmodule

/* rtl/camera_command_socket_tracker.sv */
// Top level of the camera command socket tracker: two sockets, two tag FIFOs.
// Depends on ccst_pkg and ccst_tag_fifo.
//
//  channel | valid       | stall       | payload | direction
//  input   | in_valid_i  | in_stall_o  | in_i    | event beats in
//  output  | out_valid_o | out_stall_i | out_o   | result beats out (0 to 2 per event)
//
// Each event is accepted in ST_IDLE, where the accept edge reads both FIFO heads from
// memory, and executed in ST_RUN, which updates sockets and queues and posts its results.
// Results pass through a four-entry queue; events are taken while at least
// two entries are free, so up to two unread results do not hold the input back.
// Reset clears sockets, queue counts and the result queue; FIFO memories
// are not cleared.
module camera_command_socket_tracker
  import ccst_pkg::*;
#(
  parameter int unsigned COMMAND_QUEUE_DEPTH = CCST_CMD_DEPTH,
  parameter int unsigned INQUIRY_QUEUE_DEPTH = CCST_INQ_DEPTH,
  parameter int unsigned TAG_BITS            = CCST_TAG_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  function automatic logic [7:0] tag_out(input logic [TAG_BITS-1:0] t);
    logic [TAG_BITS+7:0] e;
    e = {8'd0, t};
    return e[7:0];
  endfunction

  function automatic out_t mk_res(input kind_e k, input logic [7:0] t,
                                  input logic [1:0] s, input logic ok,
                                  input logic [7:0] err);
    out_t r;
    r.kind          = k;
    r.result_tag    = t;
    r.result_socket = s;
    r.success       = ok;
    r.result_error  = err;
    r.last          = 1'b0;
    return r;
  endfunction

  state_e state_q, state_d;
  logic   accept, run;

  // Beat held for the execute cycle
  logic [2:0]          op_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [1:0]          sock_q;
  logic [7:0]          err_q;
  logic [TAG_BITS+7:0] tag_ext;

  phase_e              p1_q, p1_d, p2_q, p2_d;
  logic [TAG_BITS-1:0] t1_q, t1_d, t2_q, t2_d;

  fifo_ctl_t           cmd_ctl, inq_ctl;
  fifo_stat_t          cmd_stat, inq_stat;
  logic [TAG_BITS-1:0] cmd_head, inq_head;

  out_t                rq [RQ_DEPTH];
  logic [RQ_AW-1:0]    rq_wr_q, rq_rd_q;
  logic [RQ_CW-1:0]    rq_cnt_q;
  logic                rq_pop;

  out_t                res0, res1, dres;
  logic [1:0]          n_res;
  logic [1:0]          freed;
  logic                free_ok;
  logic [7:0]          free_err;
  logic                try_disp, have_cmd, disp_slot, dispatched;
  logic [TAG_BITS-1:0] disp_head;
  logic                b1, b2;

  assign accept  = in_valid_i && !in_stall_o;
  assign tag_ext = {{TAG_BITS{1'b0}}, in_i.tag};

  // State sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RUN;
      ST_RUN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    run        = (state_q == ST_RUN);
    in_stall_o = (state_q != ST_IDLE) || (rq_cnt_q > RQ_CW'(RQ_DEPTH - 2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.op;
      tag_q  <= tag_ext[TAG_BITS-1:0];
      sock_q <= in_i.socket;
      err_q  <= in_i.error_code;
    end
  end

  ccst_tag_fifo #(
    .DEPTH (COMMAND_QUEUE_DEPTH),
    .WIDTH (TAG_BITS)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cmd_ctl),
    .wdata_i (tag_q),
    .head_o  (cmd_head),
    .stat_o  (cmd_stat)
  );

  ccst_tag_fifo #(
    .DEPTH (INQUIRY_QUEUE_DEPTH),
    .WIDTH (TAG_BITS)
  ) u_inq_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (inq_ctl),
    .wdata_i (tag_q),
    .head_o  (inq_head),
    .stat_o  (inq_stat)
  );

  // Execute step. A queued command implies both sockets busy, so at most
  // one command is dispatched per event.
  always_comb begin
    p1_d       = p1_q;
    p2_d       = p2_q;
    t1_d       = t1_q;
    t2_d       = t2_q;
    cmd_ctl    = '0;
    inq_ctl    = '0;
    res0       = '0;
    res1       = '0;
    dres       = '0;
    n_res      = 2'd0;
    freed      = SOCK_NONE;
    free_ok    = 1'b0;
    free_err   = 8'd0;
    try_disp   = 1'b0;
    have_cmd   = !cmd_stat.empty;
    disp_slot  = 1'b1;
    disp_head  = cmd_head;
    dispatched = 1'b0;
    b1         = (p1_q != PH_IDLE);
    b2         = (p2_q != PH_IDLE);

    if (run) begin
      unique case (op_e'(op_q))
        OP_SUBMIT_CMD: begin
          if (cmd_stat.full) begin
            res0  = mk_res(KIND_REJECTED, tag_out(tag_q), SOCK_NONE, 1'b0, 8'd0);
            n_res = 2'd1;
          end else begin
            cmd_ctl.push = 1'b1;
            try_disp     = 1'b1;
            have_cmd     = 1'b1;
            disp_slot    = 1'b0;
            // empty queue: the new tag is the head, forwarded past the memory
            disp_head    = cmd_stat.empty ? tag_q : cmd_head;
          end
        end
        OP_SUBMIT_INQ: begin
          if (inq_stat.full) begin
            res0 = mk_res(KIND_REJECTED, tag_out(tag_q), SOCK_NONE, 1'b0, 8'd0);
          end else begin
            inq_ctl.push = 1'b1;
            res0 = mk_res(KIND_SEND_INQ, tag_out(tag_q), SOCK_NONE, 1'b0, 8'd0);
          end
          n_res = 2'd1;
        end
        OP_ACK: begin
          if (sock_q == SOCK_ONE && p1_q == PH_AWAIT) begin
            p1_d = PH_EXEC;
          end else if (sock_q == SOCK_TWO && p2_q == PH_AWAIT) begin
            p2_d = PH_EXEC;
          end
        end
        OP_COMPLETION: begin
          free_ok = 1'b1;
          if (sock_q == SOCK_ONE && b1) begin
            freed = SOCK_ONE;
          end else if (sock_q == SOCK_TWO && b2) begin
            freed = SOCK_TWO;
          end else if (sock_q == SOCK_NONE) begin
            if (b1) begin
              freed = SOCK_ONE;
            end else if (b2) begin
              freed = SOCK_TWO;
            end
          end
        end
        OP_REPLY: begin
          if (!inq_stat.empty) begin
            inq_ctl.pop = 1'b1;
            res0  = mk_res(KIND_INQ_DONE, tag_out(inq_head), SOCK_NONE, 1'b1, 8'd0);
            n_res = 2'd1;
          end
        end
        OP_ERROR: begin
          free_err = err_q;
          if (sock_q == SOCK_ONE && b1) begin
            freed = SOCK_ONE;
          end else if (sock_q == SOCK_TWO && b2) begin
            freed = SOCK_TWO;
          end else if (!inq_stat.empty) begin
            inq_ctl.pop = 1'b1;
            res0  = mk_res(KIND_INQ_DONE, tag_out(inq_head), SOCK_NONE, 1'b0, err_q);
            n_res = 2'd1;
          end
        end
        OP_TIMEOUT: begin
          if (b1 && t1_q == tag_q) begin
            freed = SOCK_ONE;
          end else if (b2 && t2_q == tag_q) begin
            freed = SOCK_TWO;
          end else begin
            res0  = mk_res(KIND_CMD_DONE, tag_out(tag_q), SOCK_NONE, 1'b0, 8'd0);
            n_res = 2'd1;
          end
        end
        default: begin
        end
      endcase

      if (freed == SOCK_ONE) begin
        p1_d     = PH_IDLE;
        res0     = mk_res(KIND_CMD_DONE, tag_out(t1_q), SOCK_ONE, free_ok, free_err);
        n_res    = 2'd1;
        try_disp = 1'b1;
      end else if (freed == SOCK_TWO) begin
        p2_d     = PH_IDLE;
        res0     = mk_res(KIND_CMD_DONE, tag_out(t2_q), SOCK_TWO, free_ok, free_err);
        n_res    = 2'd1;
        try_disp = 1'b1;
      end

      if (try_disp && have_cmd) begin
        if (p1_d == PH_IDLE) begin
          p1_d       = PH_AWAIT;
          t1_d       = disp_head;
          dres       = mk_res(KIND_SEND_CMD, tag_out(disp_head), SOCK_ONE, 1'b0, 8'd0);
          dispatched = 1'b1;
        end else if (p2_d == PH_IDLE) begin
          p2_d       = PH_AWAIT;
          t2_d       = disp_head;
          dres       = mk_res(KIND_SEND_CMD, tag_out(disp_head), SOCK_TWO, 1'b0, 8'd0);
          dispatched = 1'b1;
        end
      end

      if (dispatched) begin
        cmd_ctl.pop = 1'b1;
        if (disp_slot) begin
          res1  = dres;
          n_res = 2'd2;
        end else begin
          res0  = dres;
          n_res = 2'd1;
        end
      end

      if (n_res == 2'd1) begin
        res0.last = 1'b1;
      end else if (n_res == 2'd2) begin
        res1.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= PH_IDLE;
      p2_q <= PH_IDLE;
      t1_q <= '0;
      t2_q <= '0;
    end else begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      t1_q <= t1_d;
      t2_q <= t2_d;
    end
  end

  // Result queue
  assign out_valid_o = (rq_cnt_q != '0);
  assign out_o       = rq[rq_rd_q];
  assign rq_pop      = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      rq_wr_q  <= rq_wr_q + RQ_AW'(n_res);
      rq_rd_q  <= rq_rd_q + RQ_AW'(rq_pop);
      rq_cnt_q <= rq_cnt_q + RQ_CW'(n_res) - RQ_CW'(rq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      rq[rq_wr_q] <= res0;
    end
    if (n_res == 2'd2) begin
      rq[rq_wr_q + RQ_AW'(1)] <= res1;
    end
  end

  // Checks
  a_rq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  a_queued_cmd_both_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_stat.empty |-> (p1_q != PH_IDLE && p2_q != PH_IDLE))
    else $error("command queued while a socket is idle");

  a_results_only_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_res != 2'd0) |-> run && $past(accept))
    else $error("results posted without an accepted beat");

  a_one_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_ctl.pop && !cmd_ctl.push) |-> !cmd_stat.empty)
    else $error("pop from empty command queue");

endmodule

/* verif/ccst_result_checker.sv */
// Result checker for the camera command socket tracker: watches both channels,
// predicts the result beats of every accepted event and compares them in order.
// Depends on ccst_pkg.
`timescale 1ns / 100ps

module ccst_result_checker
  import ccst_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_i,
  output int   fail_count_o,
  output int   outstanding_o
);

  phase_e     sock1_phase;
  phase_e     sock2_phase;
  logic [7:0] sock1_tag;
  logic [7:0] sock2_tag;
  logic [7:0] cmd_queue[$];
  logic [7:0] inq_queue[$];
  out_t       step_results[$];
  out_t       expected_results[$];
  int         mismatches;

  function automatic out_t make_result(kind_e kind, logic [7:0] tag, logic [1:0] sock,
                                       logic ok, logic [7:0] err);
    out_t r;
    r.kind          = kind;
    r.result_tag    = tag;
    r.result_socket = sock;
    r.success       = ok;
    r.result_error  = err;
    r.last          = 1'b0;
    return r;
  endfunction

  task automatic add_result(out_t r);
    step_results = {step_results, r};
  endtask

  // Queued commands go to idle sockets, socket one first, two beats per event at most
  task automatic dispatch_commands();
    while (cmd_queue.size() > 0 && step_results.size() < 2) begin
      if (sock1_phase == PH_IDLE) begin
        sock1_tag   = cmd_queue[0];
        cmd_queue.delete(0);
        sock1_phase = PH_AWAIT;
        add_result(make_result(KIND_SEND_CMD, sock1_tag, SOCK_ONE, 1'b0, 8'h00));
      end else if (sock2_phase == PH_IDLE) begin
        sock2_tag   = cmd_queue[0];
        cmd_queue.delete(0);
        sock2_phase = PH_AWAIT;
        add_result(make_result(KIND_SEND_CMD, sock2_tag, SOCK_TWO, 1'b0, 8'h00));
      end else begin
        break;
      end
    end
  endtask

  task automatic release_socket(logic [1:0] sock, logic ok, logic [7:0] err);
    logic [7:0] tag;
    if (sock == SOCK_ONE) begin
      sock1_phase = PH_IDLE;
      tag         = sock1_tag;
    end else begin
      sock2_phase = PH_IDLE;
      tag         = sock2_tag;
    end
    add_result(make_result(KIND_CMD_DONE, tag, sock, ok, err));
    dispatch_commands();
  endtask

  task automatic predict_event(in_t ev);
    logic busy1;
    logic busy2;
    busy1 = (sock1_phase != PH_IDLE);
    busy2 = (sock2_phase != PH_IDLE);
    step_results.delete();
    case (ev.op)
      OP_SUBMIT_CMD: begin
        if (cmd_queue.size() >= CCST_CMD_DEPTH) begin
          add_result(make_result(KIND_REJECTED, ev.tag, SOCK_NONE, 1'b0, 8'h00));
        end else begin
          cmd_queue = {cmd_queue, ev.tag};
          dispatch_commands();
        end
      end
      OP_SUBMIT_INQ: begin
        if (inq_queue.size() >= CCST_INQ_DEPTH) begin
          add_result(make_result(KIND_REJECTED, ev.tag, SOCK_NONE, 1'b0, 8'h00));
        end else begin
          inq_queue = {inq_queue, ev.tag};
          add_result(make_result(KIND_SEND_INQ, ev.tag, SOCK_NONE, 1'b0, 8'h00));
        end
      end
      OP_ACK: begin
        if (ev.socket == SOCK_ONE && sock1_phase == PH_AWAIT) begin
          sock1_phase = PH_EXEC;
        end else if (ev.socket == SOCK_TWO && sock2_phase == PH_AWAIT) begin
          sock2_phase = PH_EXEC;
        end
      end
      OP_COMPLETION: begin
        if (ev.socket == SOCK_ONE && busy1) begin
          release_socket(SOCK_ONE, 1'b1, 8'h00);
        end else if (ev.socket == SOCK_TWO && busy2) begin
          release_socket(SOCK_TWO, 1'b1, 8'h00);
        end else if (ev.socket == SOCK_NONE) begin
          // no socket named: the lower busy socket is freed
          if (busy1) begin
            release_socket(SOCK_ONE, 1'b1, 8'h00);
          end else if (busy2) begin
            release_socket(SOCK_TWO, 1'b1, 8'h00);
          end
        end
      end
      OP_REPLY: begin
        if (inq_queue.size() > 0) begin
          add_result(make_result(KIND_INQ_DONE, inq_queue[0], SOCK_NONE, 1'b1, 8'h00));
          inq_queue.delete(0);
        end
      end
      OP_ERROR: begin
        if (ev.socket == SOCK_ONE && busy1) begin
          release_socket(SOCK_ONE, 1'b0, ev.error_code);
        end else if (ev.socket == SOCK_TWO && busy2) begin
          release_socket(SOCK_TWO, 1'b0, ev.error_code);
        end else if (inq_queue.size() > 0) begin
          // unclaimed error fails the oldest inquiry
          add_result(make_result(KIND_INQ_DONE, inq_queue[0], SOCK_NONE, 1'b0,
                                 ev.error_code));
          inq_queue.delete(0);
        end
      end
      OP_TIMEOUT: begin
        if (busy1 && sock1_tag == ev.tag) begin
          sock1_phase = PH_IDLE;
          add_result(make_result(KIND_CMD_DONE, ev.tag, SOCK_ONE, 1'b0, 8'h00));
          dispatch_commands();
        end else if (busy2 && sock2_tag == ev.tag) begin
          sock2_phase = PH_IDLE;
          add_result(make_result(KIND_CMD_DONE, ev.tag, SOCK_TWO, 1'b0, 8'h00));
          dispatch_commands();
        end else begin
          add_result(make_result(KIND_CMD_DONE, ev.tag, SOCK_NONE, 1'b0, 8'h00));
        end
      end
      default: begin
      end
    endcase
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
    expected_results = {expected_results, step_results};
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result beat: kind %0d tag %h socket %0d success %b error %h last %b",
                 got.kind, got.result_tag, got.result_socket, got.success,
                 got.result_error, got.last);
      end
    end else begin
      want = expected_results[0];
      expected_results.delete(0);
      if (got.kind != want.kind || got.result_tag != want.result_tag ||
          got.result_socket != want.result_socket || got.success != want.success ||
          got.result_error != want.result_error || got.last != want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected kind %0d tag %h socket %0d success %b error %h last %b",
                   want.kind, want.result_tag, want.result_socket, want.success,
                   want.result_error, want.last);
          $display("                 actual   kind %0d tag %h socket %0d success %b error %h last %b",
                   got.kind, got.result_tag, got.result_socket, got.success,
                   got.result_error, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sock1_phase = PH_IDLE;
      sock2_phase = PH_IDLE;
      sock1_tag   = 8'h00;
      sock2_tag   = 8'h00;
      cmd_queue.delete();
      inq_queue.delete();
      expected_results.delete();
      mismatches    = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_event(in_i);
      if (out_valid_i && !out_stall_i) check_result(out_i);
      fail_count_o  <= mismatches;
      outstanding_o <= expected_results.size();
    end
  end

endmodule

/* verif/tb_camera_command_socket_tracker.sv */
// Testbench top for the camera command socket tracker: clock, reset, event stimulus
// with random sender gaps and receiver stalls, and the verdict.
// Depends on ccst_pkg, camera_command_socket_tracker and ccst_result_checker.
`timescale 1ns / 100ps

module tb_camera_command_socket_tracker;
  import ccst_pkg::*;

  localparam logic [2:0] OP_UNUSED      = 3'd7;
  localparam logic [1:0] SOCK_RESERVED  = 2'd3;
  localparam int         ITEMS_PER_PASS = 450;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid    = 1'b0;
  in_t  in_data     = '0;
  logic out_stall   = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   outstanding;

  int         send_idle_pct  = 37;
  int         recv_stall_pct = 49;
  logic [7:0] recent_tags[$];

  camera_command_socket_tracker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data)
  );

  ccst_result_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_i          (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_i         (out_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic in_t mk_event(logic [2:0] op, logic [7:0] tag, logic [1:0] sock,
                                   logic [7:0] err);
    in_t ev;
    ev.op         = op;
    ev.tag        = tag;
    ev.socket     = sock;
    ev.error_code = err;
    return ev;
  endfunction

  // Mostly well-formed traffic: sockets 1 and 2 dominate, timeouts mostly reuse recent command tags
  function automatic in_t random_event();
    in_t ev;
    int  r;
    ev = mk_event(OP_UNUSED, 8'($urandom), 2'($urandom), 8'($urandom));
    r  = $urandom_range(0, 99);
    if (r < 24) begin
      ev.op = OP_SUBMIT_CMD;
    end else if (r < 34) begin
      ev.op = OP_SUBMIT_INQ;
    end else if (r < 50) begin
      ev.op = OP_ACK;
      if ($urandom_range(0, 9) != 0) ev.socket = 2'($urandom_range(1, 2));
    end else if (r < 66) begin
      ev.op = OP_COMPLETION;
      r = $urandom_range(0, 19);
      ev.socket = (r < 4) ? SOCK_NONE : (r < 11) ? SOCK_ONE : (r < 18) ? SOCK_TWO : SOCK_RESERVED;
    end else if (r < 74) begin
      ev.op = OP_REPLY;
    end else if (r < 84) begin
      ev.op = OP_ERROR;
    end else if (r < 97) begin
      ev.op = OP_TIMEOUT;
      if (recent_tags.size() > 0 && $urandom_range(0, 3) != 0) begin
        ev.tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
      end
    end
    return ev;
  endfunction

  // Present one beat, with random idle cycles ahead of it, and hold it until taken
  task automatic send_event(in_t ev);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (ev.op == OP_SUBMIT_CMD) begin
      recent_tags = {recent_tags, ev.tag};
      if (recent_tags.size() > 8) recent_tags.delete(0);
    end
  endtask

  initial begin
    int   pass_idx;
    int   count;
    int   pick;
    in_t  ev;
    logic [2:0] flood_op;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: events on an empty block (only the timeout posts a result), then both sockets and both queues
    send_event(mk_event(OP_REPLY,      8'h00, SOCK_NONE,     8'h00));
    send_event(mk_event(OP_ERROR,      8'hFF, SOCK_NONE,     8'hFF));
    send_event(mk_event(OP_COMPLETION, 8'h00, SOCK_NONE,     8'h00));
    send_event(mk_event(OP_TIMEOUT,    8'h00, SOCK_NONE,     8'h00));
    send_event(mk_event(OP_ACK,        8'h00, SOCK_ONE,      8'h00));
    send_event(mk_event(OP_UNUSED,     8'hFF, SOCK_RESERVED, 8'hFF));
    send_event(mk_event(OP_SUBMIT_CMD, 8'hFF, SOCK_NONE,     8'h00));
    send_event(mk_event(OP_SUBMIT_CMD, 8'h00, SOCK_RESERVED, 8'hFF));
    send_event(mk_event(OP_SUBMIT_CMD, 8'hA5, SOCK_NONE,     8'h00));
    send_event(mk_event(OP_ACK,        8'h00, SOCK_ONE,      8'h00));
    send_event(mk_event(OP_ACK,        8'h00, SOCK_RESERVED, 8'h00));
    send_event(mk_event(OP_COMPLETION, 8'h00, SOCK_RESERVED, 8'h00));
    send_event(mk_event(OP_COMPLETION, 8'h00, SOCK_NONE,     8'h00));
    send_event(mk_event(OP_SUBMIT_INQ, 8'h5A, SOCK_NONE,     8'h00));
    send_event(mk_event(OP_SUBMIT_INQ, 8'hFF, SOCK_TWO,      8'h00));
    send_event(mk_event(OP_ERROR,      8'h00, SOCK_RESERVED, 8'hFF));
    send_event(mk_event(OP_REPLY,      8'hFF, SOCK_NONE,     8'h00));
    send_event(mk_event(OP_ERROR,      8'h00, SOCK_TWO,      8'h80));
    send_event(mk_event(OP_ACK,        8'h00, SOCK_ONE,      8'h00));
    send_event(mk_event(OP_COMPLETION, 8'h00, SOCK_TWO,      8'h00));
    send_event(mk_event(OP_TIMEOUT,    8'hA5, SOCK_NONE,     8'h00));
    send_event(mk_event(OP_ERROR,      8'h7F, SOCK_ONE,      8'h01));

    for (pass_idx = 0; pass_idx < 3; pass_idx++) begin
      case (pass_idx)
        0: begin send_idle_pct = 37; recv_stall_pct = 49; end
        1: begin send_idle_pct = 49; recv_stall_pct = 37; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      count = 0;
      while (count < ITEMS_PER_PASS) begin
        // each pass opens with a flood so that a queue overflows
        pick = (count == 0) ? 0 : $urandom_range(0, 59);
        if (pick == 0) begin
          if (count == 0) flood_op = (pass_idx == 1) ? OP_SUBMIT_INQ : OP_SUBMIT_CMD;
          else flood_op = $urandom_range(0, 1) ? OP_SUBMIT_INQ : OP_SUBMIT_CMD;
          repeat (20) begin
            ev    = random_event();
            ev.op = flood_op;
            send_event(ev);
            count++;
          end
        end else if (pick == 1) begin
          // drain burst: acks, completions, replies and timeouts on the latest command tag
          repeat (16) begin
            ev = random_event();
            case ($urandom_range(0, 3))
              0: ev.op = OP_ACK;
              1: begin ev.op = OP_COMPLETION; ev.socket = SOCK_NONE; end
              2: ev.op = OP_REPLY;
              default: begin
                ev.op = OP_TIMEOUT;
                if (recent_tags.size() > 0) ev.tag = recent_tags[recent_tags.size() - 1];
              end
            endcase
            send_event(ev);
            count++;
          end
        end else begin
          ev = random_event();
          send_event(ev);
          if (ev.op != OP_UNUSED) count++;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count + outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ccst_pkg.sv
rtl/ccst_tag_fifo.sv
rtl/camera_command_socket_tracker.sv
verif/ccst_result_checker.sv
verif/tb_camera_command_socket_tracker.sv
